// File: rtl/edt_pkg.sv
`default_nettype none
package edt_pkg;

  // field widths
  localparam int VALUE_W   = 48;
  localparam int TIME_W    = 63;
  localparam int DD_W      = 32;
  localparam int FRAC_BITS = 16;

  // shared adder width: two guard bits over a signed value
  localparam int ALU_W = VALUE_W + 2;
  localparam int CNT_W = $clog2(DD_W);

  // packed stream widths
  localparam int IN_DATA_W  = ((VALUE_W + TIME_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TIME_W + VALUE_W + 2 * DD_W + 7) / 8) * 8;

  localparam logic [VALUE_W-1:0] CAP_RESET = VALUE_W'(1000000000);
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(DD_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_PEAK,
    ST_DIFF,
    ST_SAT,
    ST_DIV,
    ST_MAX,
    ST_FIN
  } edt_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } edt_alu_op_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic fire;      // request accepted
    logic peak_pos;  // peak strictly positive
    logic alu_neg;   // shared unit result negative
    logic out_free;  // output register can take a result
  } edt_status_t;

  // per-cycle controls from the sequencer
  typedef struct packed {
    logic        in_ready;
    logic        ld_equity;
    logic        ld_peak;
    logic        ld_diff;
    logic        sat_chk;
    logic        div_step;
    logic        ld_worst;
    logic        emit;
    edt_alu_op_t op;
  } edt_ctrl_t;

endpackage
`default_nettype wire

// File: rtl/edt_alu.sv
`default_nettype none
module edt_alu (
  input  wire logic [edt_pkg::ALU_W-1:0] a,
  input  wire logic [edt_pkg::ALU_W-1:0] b,
  input  wire edt_pkg::edt_alu_op_t      op,
  output logic      [edt_pkg::ALU_W-1:0] res
);

  // single add/subtract used by every step of the sequence
  always_comb begin
    if (op == edt_pkg::ALU_SUB) begin
      res = a - b;
    end else begin
      res = a + b;
    end
  end

endmodule
`default_nettype wire

// File: rtl/edt_fsm.sv
`default_nettype none
module edt_fsm (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire edt_pkg::edt_status_t  status,
  output edt_pkg::edt_state_t        state,
  output edt_pkg::edt_ctrl_t         ctrl
);

  edt_pkg::edt_state_t        state_r, state_nxt;
  logic [edt_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       div_last;

  assign state    = state_r;
  assign div_last = (cnt_r == edt_pkg::DIV_LAST);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      edt_pkg::ST_IDLE: if (status.fire) state_nxt = edt_pkg::ST_ADD;
      edt_pkg::ST_ADD:  state_nxt = edt_pkg::ST_PEAK;
      edt_pkg::ST_PEAK: state_nxt = edt_pkg::ST_DIFF;
      edt_pkg::ST_DIFF: begin
        state_nxt = status.peak_pos ? edt_pkg::ST_SAT : edt_pkg::ST_MAX;
      end
      edt_pkg::ST_SAT: begin
        state_nxt = status.alu_neg ? edt_pkg::ST_DIV : edt_pkg::ST_MAX;
      end
      edt_pkg::ST_DIV:  if (div_last) state_nxt = edt_pkg::ST_MAX;
      edt_pkg::ST_MAX:  state_nxt = edt_pkg::ST_FIN;
      edt_pkg::ST_FIN:  if (status.out_free) state_nxt = edt_pkg::ST_IDLE;
      default:          state_nxt = edt_pkg::ST_IDLE;
    endcase
  end

  // divide step counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == edt_pkg::ST_DIV) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = '0;
    end
  end

  // outputs
  always_comb begin
    ctrl = '0;
    ctrl.op = edt_pkg::ALU_SUB;
    case (state_r)
      edt_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      edt_pkg::ST_ADD: begin
        ctrl.ld_equity = 1'b1;
        ctrl.op        = edt_pkg::ALU_ADD;
      end
      edt_pkg::ST_PEAK: ctrl.ld_peak  = 1'b1;
      edt_pkg::ST_DIFF: ctrl.ld_diff  = 1'b1;
      edt_pkg::ST_SAT:  ctrl.sat_chk  = 1'b1;
      edt_pkg::ST_DIV:  ctrl.div_step = 1'b1;
      edt_pkg::ST_MAX:  ctrl.ld_worst = 1'b1;
      edt_pkg::ST_FIN:  ctrl.emit     = status.out_free;
      default:          ctrl.op       = edt_pkg::ALU_SUB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= edt_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/equity_drawdown_tracker.sv
`default_nettype none
// Steps: add, peak update, difference, saturation check, restoring divide,
// worst-drawdown update, output once the output register is free; a saturated
// ratio skips the divide, a peak that is not positive also the saturation check.
// One trade at a time; the 32 divide steps share the single add/subtract unit.
// Reset (rst_n, synchronous, active low): capital, equity and peak return to
// 1000000000, worst drawdown to 0, sequencer to idle, no result pending.
module equity_drawdown_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: trade_pnl[47:0], trade_time[110:48], zero pad [111]
  input  wire logic [edt_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: run_start[0]
  input  wire logic                           in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // out_tdata: time_out[62:0], equity_now[110:63], drawdown_now[142:111],
  //            drawdown_max[174:143], zero pad [175]
  output logic [edt_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [edt_pkg::VALUE_W-1:0]    cfg_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready
);

  localparam int VW = edt_pkg::VALUE_W;
  localparam int AW = edt_pkg::ALU_W;
  localparam int DW = edt_pkg::DD_W;
  localparam int TW = edt_pkg::TIME_W;
  localparam int FB = edt_pkg::FRAC_BITS;

  edt_pkg::edt_state_t  state;
  edt_pkg::edt_ctrl_t   ctrl;
  edt_pkg::edt_status_t status;

  logic [VW-1:0] cap_r, equity_r, peak_r, pnl_r, rem_r;
  logic [TW-1:0] time_r;
  logic [DW-1:0] worst_r, quo_r, sh_r;

  logic [AW-1:0] alu_a, alu_b, alu_res;
  logic [VW-1:0] rem_shift;
  logic          alu_neg, peak_pos, fire, out_free;

  logic          out_valid_r;
  logic [TW-1:0] out_time_r;
  logic [VW-1:0] out_eq_r;
  logic [DW-1:0] out_dnow_r, out_dmax_r;

  assign fire      = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign alu_neg   = alu_res[AW-1];
  assign peak_pos  = !peak_r[VW-1] && (peak_r != '0);
  assign rem_shift = {rem_r[VW-2:0], sh_r[DW-1]};
  assign in_tready = ctrl.in_ready;
  assign cfg_ready = 1'b1;

  assign status.fire     = fire;
  assign status.peak_pos = peak_pos;
  assign status.alu_neg  = alu_neg;
  assign status.out_free = out_free;

  edt_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .state  (state),
    .ctrl   (ctrl)
  );

  edt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (ctrl.op),
    .res (alu_res)
  );

  // operand select for the shared unit
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      edt_pkg::ST_ADD: begin
        alu_a = {{(AW-VW){equity_r[VW-1]}}, equity_r};
        alu_b = {{(AW-VW){pnl_r[VW-1]}}, pnl_r};
      end
      edt_pkg::ST_PEAK, edt_pkg::ST_DIFF: begin
        alu_a = {{(AW-VW){peak_r[VW-1]}}, peak_r};
        alu_b = {{(AW-VW){equity_r[VW-1]}}, equity_r};
      end
      edt_pkg::ST_SAT: begin
        alu_a = {{(AW-VW){1'b0}}, (rem_r >> FB)};
        alu_b = {{(AW-VW){1'b0}}, peak_r};
      end
      edt_pkg::ST_DIV: begin
        alu_a = {{(AW-VW){1'b0}}, rem_shift};
        alu_b = {{(AW-VW){1'b0}}, peak_r};
      end
      edt_pkg::ST_MAX: begin
        alu_a = {{(AW-DW){1'b0}}, quo_r};
        alu_b = {{(AW-DW){1'b0}}, worst_r};
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  // capital register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= edt_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // running state: equity, peak, worst drawdown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      equity_r <= edt_pkg::CAP_RESET;
      peak_r   <= edt_pkg::CAP_RESET;
      worst_r  <= '0;
    end else begin
      if (fire && in_tuser) begin
        equity_r <= cap_r;
        peak_r   <= cap_r;
        worst_r  <= '0;
      end
      if (ctrl.ld_equity) begin
        // saturate when the guard bits disagree with the sign
        if (alu_res[AW-1] == alu_res[VW] && alu_res[VW] == alu_res[VW-1]) begin
          equity_r <= alu_res[VW-1:0];
        end else if (alu_res[AW-1]) begin
          equity_r <= edt_pkg::VALUE_MIN;
        end else begin
          equity_r <= edt_pkg::VALUE_MAX;
        end
      end
      if (ctrl.ld_peak && alu_neg) begin
        peak_r <= equity_r;
      end
      if (ctrl.ld_worst && !alu_neg) begin
        worst_r <= quo_r;
      end
    end
  end

  // divider registers: remainder, dividend shifter, quotient
  always_ff @(posedge clk) begin
    if (fire) begin
      pnl_r  <= in_tdata[VW-1:0];
      time_r <= in_tdata[VW+TW-1:VW];
    end
    if (ctrl.ld_diff) begin
      if (peak_pos) begin
        rem_r <= alu_res[VW-1:0];
      end else begin
        quo_r <= '0;
      end
    end
    if (ctrl.sat_chk) begin
      if (alu_neg) begin
        rem_r <= rem_r >> FB;
        sh_r  <= {rem_r[FB-1:0], {(DW-FB){1'b0}}};
        quo_r <= '0;
      end else begin
        quo_r <= '1;
      end
    end
    if (ctrl.div_step) begin
      rem_r <= alu_neg ? rem_shift : alu_res[VW-1:0];
      sh_r  <= {sh_r[DW-2:0], 1'b0};
      quo_r <= {quo_r[DW-2:0], !alu_neg};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_time_r <= time_r;
      out_eq_r   <= equity_r;
      out_dnow_r <= quo_r;
      out_dmax_r <= worst_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(edt_pkg::OUT_DATA_W-TW-VW-2*DW){1'b0}},
                       out_dmax_r, out_dnow_r, out_eq_r, out_time_r};

`ifndef SYNTHESIS
  a_fire_starts: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> state == edt_pkg::ST_ADD)
    else $error("accepted request did not start the sequence");

  a_peak_above: assert property (@(posedge clk) disable iff (!rst_n)
    state == edt_pkg::ST_DIFF |-> $signed(peak_r) >= $signed(equity_r))
    else $error("peak below equity after peak update");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state == edt_pkg::ST_DIV |-> rem_r < peak_r)
    else $error("divider remainder not below divisor");

  a_worst_mono: assert property (@(posedge clk) disable iff (!rst_n)
    state != edt_pkg::ST_IDLE |=> worst_r >= $past(worst_r))
    else $error("worst drawdown decreased within a trade");

  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_dmax_r >= out_dnow_r)
    else $error("max drawdown below current drawdown");
`endif

endmodule
`default_nettype wire

// File: dv/tb_equity_drawdown_tracker.sv
module tb_equity_drawdown_tracker;

  localparam int VALUE_W    = edt_pkg::VALUE_W;
  localparam int TIME_W     = edt_pkg::TIME_W;
  localparam int DD_W       = edt_pkg::DD_W;
  localparam int FRAC_BITS  = edt_pkg::FRAC_BITS;
  localparam int IN_DATA_W  = edt_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = edt_pkg::OUT_DATA_W;

  localparam logic [VALUE_W-1:0] CAP_RESET = edt_pkg::CAP_RESET;
  localparam logic [VALUE_W-1:0] VALUE_MAX = edt_pkg::VALUE_MAX;
  localparam logic [VALUE_W-1:0] VALUE_MIN = edt_pkg::VALUE_MIN;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 100;
  localparam int PHASE_ITEMS = 172;
  localparam int SHOW_MAX    = 10;

  localparam logic [TIME_W-1:0]  STAMP_MAX = {TIME_W{1'b1}};
  localparam logic [DD_W-1:0]    DD_FULL   = {DD_W{1'b1}};
  localparam logic [VALUE_W-1:0] NEG_ONE   = {VALUE_W{1'b1}};

  // out_tdata field offsets, lowest bit up
  localparam int EQ_LO  = TIME_W;
  localparam int DDN_LO = TIME_W + VALUE_W;
  localparam int DDX_LO = TIME_W + VALUE_W + DD_W;

  typedef struct packed {
    logic [TIME_W-1:0]  stamp;
    logic [VALUE_W-1:0] equity;
    logic [DD_W-1:0]    dd_now;
    logic [DD_W-1:0]    dd_max;
  } equity_mark_t;

  typedef struct {
    bit                 wr_cap;
    logic [VALUE_W-1:0] cap;
    logic [VALUE_W-1:0] pnl;
    logic [TIME_W-1:0]  stamp;
    bit                 start;
    bit                 typed;
    equity_mark_t       want;
  } trade_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [VALUE_W-1:0]    cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  // shadow of the block's state
  logic [VALUE_W-1:0] shadow_capital = CAP_RESET;
  logic [VALUE_W-1:0] shadow_equity  = CAP_RESET;
  logic [VALUE_W-1:0] shadow_peak    = CAP_RESET;
  logic [DD_W-1:0]    shadow_worst   = '0;

  equity_mark_t marks_due[$];
  trade_row_t   trade_rows[$];
  int           faults = 0;
  int           cycles = 0;
  bit           send_quiet = 1'b0;
  bit           recv_quiet = 1'b0;

  equity_drawdown_tracker DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // apply one trade to the shadow state, return the mark it produces
  function automatic equity_mark_t book_trade(input logic [VALUE_W-1:0] pnl,
                                              input logic [TIME_W-1:0] stamp,
                                              input bit start);
    logic [VALUE_W+1:0] sum;
    logic [VALUE_W:0]   diff;
    logic [79:0]        quot;
    logic [DD_W-1:0]    dd;
    equity_mark_t       mark;
    if (start) begin
      shadow_equity = shadow_capital;
      shadow_peak   = shadow_capital;
      shadow_worst  = '0;
    end
    // saturating add
    sum = {{2{shadow_equity[VALUE_W-1]}}, shadow_equity} + {{2{pnl[VALUE_W-1]}}, pnl};
    if ($signed(sum) > $signed({2'b00, VALUE_MAX}))
      shadow_equity = VALUE_MAX;
    else if ($signed(sum) < $signed({2'b11, VALUE_MIN}))
      shadow_equity = VALUE_MIN;
    else
      shadow_equity = sum[VALUE_W-1:0];
    if ($signed(shadow_equity) > $signed(shadow_peak))
      shadow_peak = shadow_equity;
    // drawdown ratio, only for a positive peak
    dd = '0;
    if ($signed(shadow_peak) > 0) begin
      diff = {1'b0, shadow_peak} - {shadow_equity[VALUE_W-1], shadow_equity};
      quot = (80'(diff) << FRAC_BITS) / 80'(shadow_peak);
      dd = (quot > 80'(DD_FULL)) ? DD_FULL : quot[DD_W-1:0];
    end
    if (dd > shadow_worst)
      shadow_worst = dd;
    mark.stamp  = stamp;
    mark.equity = shadow_equity;
    mark.dd_now = dd;
    mark.dd_max = shadow_worst;
    return mark;
  endfunction

  function automatic void add_row(input bit wr_cap, input logic [VALUE_W-1:0] cap,
                                  input logic [VALUE_W-1:0] pnl,
                                  input logic [TIME_W-1:0] stamp, input bit start,
                                  input bit typed, input equity_mark_t want);
    trade_row_t row;
    row.wr_cap = wr_cap;
    row.cap    = cap;
    row.pnl    = pnl;
    row.stamp  = stamp;
    row.start  = start;
    row.typed  = typed;
    row.want   = want;
    trade_rows = {trade_rows, row};
  endfunction

  function automatic logic [TIME_W-1:0] draw_stamp();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // mostly moderate sizes, some full range, some extremes
  function automatic logic [VALUE_W-1:0] draw_pnl();
    logic [VALUE_W-1:0] raw;
    int                 pick;
    int                 len;
    pick = $urandom_range(0, 19);
    raw  = VALUE_W'({$urandom, $urandom});
    case (pick)
      0: raw = VALUE_MAX;
      1: raw = VALUE_MIN;
      2: raw = '0;
      3: raw = NEG_ONE;
      default: begin
        len = (pick < 14) ? $urandom_range(12, 32) : $urandom_range(1, VALUE_W - 1);
        raw = raw & ((VALUE_W'(1) << len) - 1);
        if ($urandom_range(0, 1))
          raw = -raw;
      end
    endcase
    return raw;
  endfunction

  // send one trade request and record what it should produce
  task automatic push_trade(input logic [VALUE_W-1:0] pnl, input logic [TIME_W-1:0] stamp,
                            input bit start, input bit typed, input equity_mark_t want);
    int           gap;
    equity_mark_t forecast;
    gap = send_quiet ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 39) == 0)
      send_quiet = !send_quiet;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= IN_DATA_W'({stamp, pnl});
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    forecast = book_trade(pnl, stamp, start);
    if (typed)
      forecast = want;
    marks_due = {marks_due, forecast};
  endtask

  // hold off new trades until every mark has come back
  task automatic drain_marks();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (marks_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_capital(input logic [VALUE_W-1:0] cap);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    shadow_capital = cap;
  endtask

  // result side: random stalls, compare against oldest mark
  initial begin : result_side
    int           stall;
    equity_mark_t seen;
    equity_mark_t due;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = recv_quiet ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0)
        recv_quiet = !recv_quiet;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      seen.stamp  = out_tdata[TIME_W-1:0];
      seen.equity = out_tdata[EQ_LO +: VALUE_W];
      seen.dd_now = out_tdata[DDN_LO +: DD_W];
      seen.dd_max = out_tdata[DDX_LO +: DD_W];
      if (marks_due.size() == 0) begin
        faults++;
        if (faults <= SHOW_MAX)
          $display("[%0d] unexpected result: time %h equity %h dd %h max %h",
                   cycles, seen.stamp, seen.equity, seen.dd_now, seen.dd_max);
      end else begin
        due = marks_due.pop_front();
        if (seen.stamp !== due.stamp || seen.equity !== due.equity ||
            seen.dd_now !== due.dd_now || seen.dd_max !== due.dd_max) begin
          faults++;
          if (faults <= SHOW_MAX) begin
            $display("[%0d] mismatch: exp time %h equity %h dd %h max %h", cycles,
                     due.stamp, due.equity, due.dd_now, due.dd_max);
            $display("[%0d]           got time %h equity %h dd %h max %h", cycles,
                     seen.stamp, seen.equity, seen.dd_now, seen.dd_max);
          end
        end
      end
    end
  end

  // stimulus
  initial begin : trade_side
    logic [VALUE_W-1:0] phase_caps[7];
    logic [VALUE_W-1:0] half_loss;
    logic [VALUE_W-1:0] big_loss;
    int                 run_left;
    bit                 start;

    half_loss = -VALUE_W'(500000000);
    big_loss  = -VALUE_W'(1500000000);

    // after reset, capital 1e9: half loss, saturation both ways
    add_row(0, '0, '0, '0, 0, 1, '{'0, CAP_RESET, '0, '0});
    add_row(0, '0, half_loss, 1, 0, 1, '{1, VALUE_W'(500000000), 32'h8000, 32'h8000});
    add_row(0, '0, VALUE_MAX, 2, 0, 1, '{2, VALUE_MAX, '0, 32'h8000});
    add_row(0, '0, VALUE_MIN, 3, 0, 1, '{3, NEG_ONE, 32'h10000, 32'h10000});
    add_row(0, '0, VALUE_MIN, 4, 0, 1, '{4, VALUE_MIN, 32'h20000, 32'h20000});
    // run start reloads capital and clears the worst drawdown
    add_row(0, '0, '0, STAMP_MAX, 1, 1, '{STAMP_MAX, CAP_RESET, '0, '0});
    add_row(0, '0, NEG_ONE, draw_stamp(), 0, 0, '0);
    add_row(0, '0, VALUE_W'(1), draw_stamp(), 0, 0, '0);
    add_row(0, '0, VALUE_W'(500000000), draw_stamp(), 0, 0, '0);
    add_row(0, '0, big_loss, 9, 0, 1, '{9, '0, 32'h10000, 32'h10000});
    add_row(0, '0, big_loss, 10, 0, 1, '{10, big_loss, 32'h20000, 32'h20000});
    // capital 1: ratio overflow saturates
    add_row(1, VALUE_W'(1), NEG_ONE, 11, 1, 1, '{11, '0, 32'h10000, 32'h10000});
    add_row(0, '0, VALUE_MIN, 12, 0, 1, '{12, VALUE_MIN, DD_FULL, DD_FULL});
    add_row(0, '0, VALUE_MAX, 13, 0, 1, '{13, NEG_ONE, 32'h20000, DD_FULL});
    // capital 0: peak not positive gives no drawdown
    add_row(1, '0, -VALUE_W'(5), 14, 1, 1, '{14, -VALUE_W'(5), '0, '0});
    add_row(0, '0, VALUE_W'(7), 15, 0, 1, '{15, VALUE_W'(2), '0, '0});
    add_row(0, '0, -VALUE_W'(3), 16, 0, 1, '{16, NEG_ONE, 32'h18000, 32'h18000});
    // most negative capital, floor saturation
    add_row(1, VALUE_MIN, VALUE_MIN, 17, 1, 1, '{17, VALUE_MIN, '0, '0});
    add_row(0, '0, VALUE_MAX, 18, 0, 1, '{18, NEG_ONE, '0, '0});
    // write mid-run: equity continues until the next run start
    add_row(1, VALUE_MAX, VALUE_W'(2), 19, 0, 1, '{19, VALUE_W'(1), '0, '0});
    add_row(0, '0, VALUE_MAX, 20, 1, 1, '{20, VALUE_MAX, '0, '0});
    add_row(0, '0, NEG_ONE, 21, 0, 1, '{21, VALUE_MAX - 1, '0, '0});
    add_row(0, '0, draw_pnl(), draw_stamp(), 0, 0, '0);
    add_row(0, '0, draw_pnl(), draw_stamp(), 1, 0, '0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (trade_rows[i]) begin
      if (trade_rows[i].wr_cap) begin
        drain_marks();
        write_capital(trade_rows[i].cap);
      end
      push_trade(trade_rows[i].pnl, trade_rows[i].stamp, trade_rows[i].start,
                 trade_rows[i].typed, trade_rows[i].want);
    end

    // random phases, one capital setting each
    phase_caps[0] = VALUE_MAX;
    phase_caps[1] = CAP_RESET;
    phase_caps[2] = VALUE_MIN;
    phase_caps[3] = '0;
    phase_caps[4] = VALUE_W'(1);
    phase_caps[5] = VALUE_W'($urandom_range(1, 32'h7FFF_FFFF)) << $urandom_range(0, 16);
    phase_caps[6] = VALUE_W'({$urandom, $urandom});

    foreach (phase_caps[p]) begin
      drain_marks();
      write_capital(phase_caps[p]);
      // the first phase item sometimes continues the old run
      run_left = $urandom_range(0, 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2)
          drain_marks();
        if (run_left == 0) begin
          start    = 1'b1;
          run_left = $urandom_range(1, 40);
        end else begin
          // stray restarts mid-run now and then
          start = ($urandom_range(0, 19) == 0);
        end
        run_left--;
        push_trade(draw_pnl(), draw_stamp(), start, 0, '0);
      end
    end

    drain_marks();
    repeat (SETTLE) @(posedge clk);
    if (faults == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
